// ===== sv/kmp_pkg.sv =====
// Shared types, op codes and widths for the first-match KMP search block.
`default_nettype none
package kmp_pkg;

	localparam int POS_OUT_W = 16;

	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_TEXT    = 2'd1;
	localparam logic [1:0] OP_END     = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} kmp_item_t;

	typedef struct packed {
		logic                 found;
		logic [POS_OUT_W-1:0] position;
		logic                 pattern_overflow;
		logic                 text_overflow;
	} kmp_res_t;

endpackage
`default_nettype wire

// ===== sv/kmp_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none
interface kmp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/kmp_ram.sv =====
// Single write port, single read port RAM with registered read data.
`default_nettype none
module kmp_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/kmp_ctrl.sv =====
// Sequencer for pattern load, failure table build and text matching.
`default_nettype none
module kmp_ctrl #(
	parameter int MAX_PATTERN_LENGTH = 32,
	parameter int POSITION_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       op,
	input  wire logic [7:0]       data_byte,
	output logic                  ready,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output kmp_pkg::kmp_res_t     res
);
	import kmp_pkg::*;

	localparam int IW = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
	localparam int CW = $clog2(MAX_PATTERN_LENGTH + 1);
	localparam int PB = POSITION_BITS;
	localparam int SW = ((PB > CW) ? PB : CW) + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_BINIT  = 4'd1;
	localparam logic [3:0] S_BQ     = 4'd2;
	localparam logic [3:0] S_BK     = 4'd3;
	localparam logic [3:0] S_BCMP   = 4'd4;
	localparam logic [3:0] S_BF     = 4'd5;
	localparam logic [3:0] S_TSTART = 4'd6;
	localparam logic [3:0] S_TCMP   = 4'd7;
	localparam logic [3:0] S_RESULT = 4'd8;

	logic [3:0]    state_q;
	logic [CW-1:0] pcount_q;
	logic          table_ready_q;
	logic [IW-1:0] midx_q;
	logic [PB-1:0] tcount_q;
	logic          found_q;
	logic [PB-1:0] mpos_q;
	logic          povf_q;
	logic          tovf_q;
	kmp_res_t      res_q;

	// build loop registers
	logic [CW-1:0] q_q;
	logic [IW-1:0] k_q;
	logic [7:0]    cq_q;
	logic [7:0]    byte_q;

	logic          p_we;
	logic [IW-1:0] p_raddr;
	logic [7:0]    p_rdata;
	logic          f_we;
	logic [IW-1:0] f_waddr;
	logic [IW-1:0] f_wdata;
	logic [IW-1:0] f_raddr;
	logic [IW-1:0] f_rdata;

	logic          eq;
	logic          tcount_sat;
	logic          build_more;
	logic          tdone;
	logic [CW-1:0] jn;
	logic [SW-1:0] mpos_full;

	kmp_ram #(.DEPTH(MAX_PATTERN_LENGTH), .WIDTH(8)) u_pattern (
		.clk   (clk),
		.we    (p_we),
		.waddr (pcount_q[IW-1:0]),
		.wdata (data_byte),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	kmp_ram #(.DEPTH(MAX_PATTERN_LENGTH), .WIDTH(IW)) u_failure (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	// Shared byte compare: pattern byte q during build, text byte during match.
	assign eq = (((state_q == S_BCMP) ? cq_q : byte_q) == p_rdata);

	assign tcount_sat = (tcount_q == {PB{1'b1}});
	assign build_more = (({1'b0, q_q} + (CW+1)'(2)) < {1'b0, pcount_q});
	assign tdone      = eq || (midx_q == '0);
	assign jn         = eq ? (CW'(midx_q) + CW'(1)) : '0;
	assign mpos_full  = SW'(tcount_q) + SW'(1) - SW'(pcount_q);

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	assign p_we = ready && start && (op == OP_PATTERN)
		&& (pcount_q < CW'(MAX_PATTERN_LENGTH));

	always_comb begin
		p_raddr = midx_q;
		f_raddr = midx_q;
		f_we    = 1'b0;
		f_waddr = IW'(1);
		f_wdata = '0;
		case (state_q)
			S_BINIT: begin
				f_we = (pcount_q > CW'(1));
			end
			S_BQ: begin
				p_raddr = q_q[IW-1:0];
			end
			S_BK: begin
				p_raddr = k_q;
			end
			S_BCMP: begin
				f_raddr = k_q;
				f_we    = eq || (k_q == '0);
				f_waddr = IW'(q_q + CW'(1));
				f_wdata = eq ? (k_q + IW'(1)) : '0;
			end
			S_BF: begin
				p_raddr = f_rdata;
			end
			S_TCMP: begin
				p_raddr = f_rdata;
				f_raddr = f_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pcount_q      <= '0;
			table_ready_q <= 1'b0;
			midx_q        <= '0;
			tcount_q      <= '0;
			found_q       <= 1'b0;
			mpos_q        <= '0;
			povf_q        <= 1'b0;
			tovf_q        <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op)
							OP_PATTERN: begin
								if (pcount_q < CW'(MAX_PATTERN_LENGTH)) begin
									pcount_q <= pcount_q + CW'(1);
								end else begin
									povf_q <= 1'b1;
								end
								table_ready_q <= 1'b0;
								midx_q   <= '0;
								tcount_q <= '0;
								found_q  <= 1'b0;
								tovf_q   <= 1'b0;
							end
							OP_TEXT: begin
								if (tcount_sat) begin
									tovf_q <= 1'b1;
								end else if (!table_ready_q) begin
									state_q <= S_BINIT;
								end else begin
									state_q <= S_TSTART;
								end
							end
							OP_END: begin
								state_q <= S_RESULT;
								midx_q   <= '0;
								tcount_q <= '0;
								found_q  <= 1'b0;
								tovf_q   <= 1'b0;
							end
							default: begin
								pcount_q      <= '0;
								table_ready_q <= 1'b0;
								povf_q        <= 1'b0;
								midx_q   <= '0;
								tcount_q <= '0;
								found_q  <= 1'b0;
								tovf_q   <= 1'b0;
							end
						endcase
					end
				end
				S_BINIT: begin
					if (pcount_q > CW'(2)) begin
						state_q <= S_BQ;
					end else begin
						table_ready_q <= 1'b1;
						state_q       <= S_TSTART;
					end
				end
				S_BQ: begin
					state_q <= S_BK;
				end
				S_BK: begin
					state_q <= S_BCMP;
				end
				S_BCMP: begin
					if (eq || (k_q == '0)) begin
						if (build_more) begin
							state_q <= S_BQ;
						end else begin
							table_ready_q <= 1'b1;
							state_q       <= S_TSTART;
						end
					end else begin
						state_q <= S_BF;
					end
				end
				S_BF: begin
					state_q <= S_BCMP;
				end
				S_TSTART: begin
					if (found_q || (pcount_q == '0)) begin
						tcount_q <= tcount_q + PB'(1);
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_TCMP;
					end
				end
				S_TCMP: begin
					if (tdone) begin
						if (jn == pcount_q) begin
							found_q <= 1'b1;
							mpos_q  <= mpos_full[PB-1:0];
							midx_q  <= '0;
						end else begin
							midx_q <= jn[IW-1:0];
						end
						tcount_q <= tcount_q + PB'(1);
						state_q  <= S_IDLE;
					end else begin
						// follow the failure link
						midx_q <= f_rdata;
					end
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: build indices, held bytes and the pending result.
	always_ff @(posedge clk) begin
		if (ready && start) begin
			byte_q <= data_byte;
		end
		if (ready && start && (op == OP_END)) begin
			res_q.found    <= (pcount_q == '0) || found_q;
			res_q.position <= ((pcount_q != '0) && found_q) ? POS_OUT_W'(mpos_q) : '0;
			res_q.pattern_overflow <= povf_q;
			res_q.text_overflow    <= tovf_q;
		end
		case (state_q)
			S_BINIT: begin
				q_q <= CW'(1);
				k_q <= '0;
			end
			S_BK: begin
				cq_q <= p_rdata;
			end
			S_BCMP: begin
				if (eq || (k_q == '0)) begin
					q_q <= q_q + CW'(1);
					k_q <= eq ? (k_q + IW'(1)) : '0;
				end
			end
			S_BF: begin
				k_q <= f_rdata;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_midx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pcount_q == '0) || (CW'(midx_q) < pcount_q))
		else $error("match index reached pattern length");

	a_found_idx: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (midx_q == '0))
		else $error("match index not cleared after first match");

	a_tovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tovf_q |-> tcount_sat)
		else $error("text overflow flagged below saturation");

	a_border_lt: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_BK) || (state_q == S_BCMP) || (state_q == S_BF))
		|-> (CW'(k_q) < q_q))
		else $error("border length not below build index");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_q)))
		else $error("pending result lost or changed");
`endif
endmodule
`default_nettype wire

// ===== sv/kmp_first_match_search.sv =====
// Top level of the first-match KMP search block with its output register.
//
// Usage: items enter on the item channel (op, data_byte); op 0 appends a
// pattern byte, op 1 streams a text byte, op 2 ends the text, op 3 clears the
// pattern. Only op 2 yields a transaction on the result channel: found,
// position of the first match, pattern_overflow and text_overflow.
// Ops 0 and 3 finish in the idle state; op 2 passes the result state to the
// result register. Op 1 passes a start state, then a compare state repeated
// per failure link followed in the shared byte compare; after the first match
// or with an empty pattern it skips the compare, and once the count saturates
// it only sets the overflow flag. The first text byte after a pattern change
// first builds the failure table: an init state, then BQ, BK, BCMP per position
// and BF, BCMP per link, bounded by the single read port of the pattern RAM.
// The block accepts no item while the sequencer works on one.
// Reset clears the pattern count, flags and text state; RAM contents are
// left as they are and are rewritten before use.
// When the receiver stalls, one result waits in the output register while
// new items are still taken; a second end-of-text item holds in the
// sequencer until the register frees.
`default_nettype none
module kmp_first_match_search #(
	parameter int MAX_PATTERN_LENGTH = 32,
	parameter int POSITION_BITS = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	kmp_stream_if.sink   item,
	kmp_stream_if.source result
);
	import kmp_pkg::*;

	logic     ctrl_ready;
	logic     res_valid;
	logic     res_ready;
	kmp_res_t res;
	logic     out_valid_q;
	kmp_res_t out_q;
	kmp_item_t in_item;

	assign in_item    = item.payload;
	assign item.ready = ctrl_ready;

	kmp_ctrl #(
		.MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
		.POSITION_BITS      (POSITION_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (item.valid),
		.op        (in_item.op),
		.data_byte (in_item.data_byte),
		.ready     (ctrl_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Load the output register whenever it is empty or being drained.
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;
endmodule
`default_nettype wire

// ===== test/tb_kmp_first_match_search.sv =====
// Self-checking testbench for the first-match KMP search block.
`default_nettype none
module tb_kmp_first_match_search;
	import kmp_pkg::*;

	localparam int          PATTERN_CAP  = 32;
	localparam int unsigned STALL_LIMIT  = 3000;  // cycles without any transaction
	localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 200;   // covers a full failure-table build
	localparam int unsigned RANDOM_ITEMS = 1300;

	// Expected-result tracker: mirrors the search state and queues one
	// verdict per end of text.
	class first_match_tracker;
		logic [7:0]  pat_bytes [PATTERN_CAP];
		int unsigned border [PATTERN_CAP];
		int unsigned pat_len;
		bit          table_valid;
		int unsigned cursor;
		logic [15:0] text_len;
		bit          hit;
		logic [15:0] hit_pos;
		bit          pat_over;
		bit          text_over;
		kmp_res_t    pending_verdicts [$];
		int unsigned errors;
		int unsigned verdicts_seen;
		int unsigned hits_seen;
		int unsigned saturated_seen;
		int unsigned pat_over_seen;

		function new();
			pat_len     = 0;
			table_valid = 0;
			pat_over    = 0;
			restart_text();
		endfunction

		function void restart_text();
			cursor    = 0;
			text_len  = '0;
			hit       = 0;
			hit_pos   = '0;
			text_over = 0;
		endfunction

		function void build_borders();
			int unsigned k;
			k = 0;
			border[0] = 0;
			if (pat_len > 1)
				border[1] = 0;
			for (int unsigned q = 1; q + 1 < pat_len; q++) begin
				while (k > 0 && pat_bytes[q] != pat_bytes[k])
					k = border[k];
				if (pat_bytes[q] == pat_bytes[k])
					k++;
				border[q + 1] = k;
			end
			table_valid = 1;
		endfunction

		function void scan_byte(logic [7:0] c);
			int unsigned j;
			bit          settled;
			if (text_len == 16'hFFFF) begin
				text_over = 1;
				return;
			end
			if (!table_valid)
				build_borders();
			if (!hit && pat_len > 0) begin
				j = cursor;
				settled = 0;
				while (!settled) begin
					if (pat_bytes[j] == c) begin
						j++;
						settled = 1;
					end else if (j == 0) begin
						settled = 1;
					end else begin
						j = border[j];
					end
				end
				if (j >= pat_len) begin
					hit     = 1;
					hit_pos = 16'(text_len + 1 - pat_len);
					j       = 0;
				end
				cursor = j;
			end
			text_len++;
		endfunction

		function void take_item(kmp_item_t it);
			kmp_res_t v;
			case (it.op)
				OP_PATTERN: begin
					if (pat_len < PATTERN_CAP) begin
						pat_bytes[pat_len] = it.data_byte;
						pat_len++;
					end else begin
						pat_over = 1;
					end
					table_valid = 0;
					restart_text();
				end
				OP_TEXT: scan_byte(it.data_byte);
				OP_END: begin
					v.found            = (pat_len == 0) ? 1'b1 : hit;
					v.position         = (pat_len != 0 && hit) ? hit_pos : '0;
					v.pattern_overflow = pat_over;
					v.text_overflow    = text_over;
					pending_verdicts.push_back(v);
					restart_text();
				end
				default: begin
					pat_len     = 0;
					table_valid = 0;
					pat_over    = 0;
					restart_text();
				end
			endcase
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(kmp_res_t got);
			kmp_res_t want;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result transaction: expected none, actual %p",
					$time, got);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			verdicts_seen++;
			if (want.found)            hits_seen++;
			if (want.text_overflow)    saturated_seen++;
			if (want.pattern_overflow) pat_over_seen++;
			compare_field("found", 16'(want.found), 16'(got.found));
			compare_field("position", want.position, got.position);
			compare_field("pattern_overflow", 16'(want.pattern_overflow),
				16'(got.pattern_overflow));
			compare_field("text_overflow", 16'(want.text_overflow), 16'(got.text_overflow));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	kmp_stream_if #(.payload_t(kmp_item_t)) item_ch ();
	kmp_stream_if #(.payload_t(kmp_res_t))  result_ch ();

	kmp_first_match_search i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	first_match_tracker tracker = new();

	bit          quiet;        // suppress idling on both sides
	bit          hold_req;     // ask the receiver for one long hold-off
	int unsigned items_sent;
	logic [7:0]  sym_base;
	int unsigned sym_span;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw an idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Pick a byte from the current alphabet; a narrow alphabet forces
	// partial matches and failure-link walks.
	function automatic logic [7:0] next_sym();
		if (sym_span >= 256)
			return 8'($urandom_range(0, 255));
		return 8'(sym_base + $urandom_range(0, sym_span - 1));
	endfunction

	// Offer one transaction on the item channel and hold it until accepted.
	// Keep valid high across back-to-back items; drop it only for a gap.
	task automatic send_item(logic [1:0] op, logic [7:0] data);
		int unsigned gap;
		kmp_item_t   it;
		gap = pick_gap();
		it.op        = op;
		it.data_byte = data;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(logic [7:0] bytes [$]);
		foreach (bytes[i])
			send_item(OP_TEXT, bytes[i]);
	endtask

	// Short directed part: empty pattern, byte extremes, no match, a pattern
	// byte arriving mid-text, clear.
	task automatic run_directed();
		send_item(OP_END, 8'h00);           // empty pattern, empty text
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_END, 8'hFF);           // empty pattern still matches at 0
		send_item(OP_PATTERN, 8'h00);
		send_item(OP_PATTERN, 8'hFF);
		send_text('{8'h12, 8'h00, 8'hFF});
		send_item(OP_END, 8'h00);           // match at position 1
		send_item(OP_END, 8'h00);           // empty text, no match
		send_item(OP_TEXT, 8'h00);
		send_item(OP_END, 8'h00);           // partial only, no match
		send_item(OP_TEXT, 8'h00);
		send_item(OP_PATTERN, 8'h00);       // restarts the text
		send_text('{8'h00, 8'hFF, 8'h00});
		send_item(OP_END, 8'h55);
		send_item(OP_CLEAR, 8'hAA);
		send_item(OP_END, 8'h00);
	endtask

	// Fill the pattern past capacity, then find the stored part.
	task automatic run_capacity();
		logic [7:0] stored [$];
		logic [7:0] b;
		send_item(OP_CLEAR, 8'h00);
		for (int i = 0; i < PATTERN_CAP + 2; i++) begin
			b = (i % 3 == 2) ? 8'h62 : 8'h61;
			send_item(OP_PATTERN, b);
			if (i < PATTERN_CAP)
				stored.push_back(b);
		end
		send_item(OP_TEXT, 8'h61);
		send_text(stored);
		send_item(OP_END, 8'h00);
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_END, 8'h00);           // overflow flag gone after clear
	endtask

	// Stall the receiver for a long stretch while several ends of text are
	// offered: one result parks in the output register, the next end of
	// text backs up the item channel.
	task automatic run_backpressure();
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_PATTERN, 8'h78);
		hold_req = 1;
		repeat (6) begin
			send_item(OP_TEXT, 8'h78);
			send_item(OP_END, 8'h00);
		end
	endtask

	// Random part: mostly well-formed pattern/text/end sequences over narrow
	// alphabets, with the pattern planted in about half of the texts, and a
	// little noise from pattern bytes and clears arriving mid-text.
	task automatic run_random(int unsigned quota);
		logic [7:0]  pat_copy [$];
		logic [7:0]  b;
		int unsigned start;
		int unsigned r;
		int unsigned plen;
		int unsigned tlen;
		int unsigned at;
		bit          plant;
		start = items_sent;
		while (items_sent < start + quota) begin
			quiet = ($urandom_range(0, 99) < 15);
			if (pat_copy.size() == 0 || $urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 3);
				sym_span = (r == 3) ? 256 : r + 2;
				sym_base = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) != 0) begin
					send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
					pat_copy.delete();
				end
				r = $urandom_range(0, 99);
				if (r < 5)       plen = 0;
				else if (r < 70) plen = $urandom_range(1, 6);
				else if (r < 92) plen = $urandom_range(7, 31);
				else             plen = $urandom_range(32, 36);
				repeat (plen) begin
					b = next_sym();
					send_item(OP_PATTERN, b);
					if (pat_copy.size() < PATTERN_CAP)
						pat_copy.push_back(b);
				end
			end
			repeat ($urandom_range(1, 4)) begin
				tlen  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24)
					: $urandom_range(25, 80);
				plant = ($urandom_range(0, 1) == 1);
				at    = $urandom_range(0, tlen);
				for (int unsigned i = 0; i <= tlen; i++) begin
					if (plant && i == at)
						send_text(pat_copy);
					if (i == tlen)
						break;
					r = $urandom_range(0, 99);
					if (r < 2) begin
						b = next_sym();
						send_item(OP_PATTERN, b);
						if (pat_copy.size() < PATTERN_CAP)
							pat_copy.push_back(b);
					end else if (r < 4) begin
						send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
						pat_copy.delete();
					end else begin
						send_item(OP_TEXT, next_sym());
					end
				end
				send_item(OP_END, 8'($urandom_range(0, 255)));
			end
		end
		quiet = 0;
	endtask

	// Receiver: accept in bursts, stall for random stretches, and serve a
	// long hold-off when asked.
	initial begin
		int unsigned n;
		result_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					result_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			n = $urandom_range(1, 8);
			repeat (n) @(posedge clk);
		end
	end

	// Monitor: note accepted items before checking results so that a result
	// and a new end of text in the same cycle keep their order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				tracker.take_item(item_ch.payload);
			if (result_ch.valid && result_ch.ready)
				tracker.check_verdict(result_ch.payload);
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	initial begin
		int unsigned stuck;
		stuck = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, stuck, tracker.pending_verdicts.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Stimulus: reset once, then the phases in order, then drain.
	initial begin
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.payload <= '0;
		quiet      = 0;
		hold_req   = 0;
		items_sent = 0;
		sym_base   = 8'h00;
		sym_span   = 256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_capacity();
		run_backpressure();
		run_random(RANDOM_ITEMS);

		item_ch.valid <= 1'b0;
		while (tracker.pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d item transactions; checked %0d end-of-text results, %0d with a match.",
			items_sent, tracker.verdicts_seen, tracker.hits_seen);
		$display("Results with pattern overflow: %0d, with saturated text count: %0d.",
			tracker.pat_over_seen, tracker.saturated_seen);
		if (tracker.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", tracker.errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
